>>> rtl/scc_pkg.sv
// shared types, constants and crc function for the scratchpad checker
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 4;
  localparam int unsigned FAULT_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TEMP_W = 16;

  localparam logic [POS_W-1:0] POS_TEMP_LOW = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_HIGH = 4'd1;
  localparam logic [POS_W-1:0] POS_CONFIG = 4'd2;
  localparam logic [POS_W-1:0] POS_CRC = 4'd8;

  localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TC_FAULT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] scratch_byte;
    logic              sensor_kind;
  } in_word_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_value;
    logic [STATUS_W-1:0]      status;
    logic [FAULT_W-1:0]       fault_bits;
  } out_word_t;

  // reflected crc-8, lsb first, one byte unrolled
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/scc_if.sv
// valid/ready channel interfaces for scratchpad bytes and check results
`timescale 1ns / 1ps
`default_nettype none
interface scc_in_if;
  logic                        valid;
  logic                        ready;
  logic [scc_pkg::BYTE_W-1:0]  scratch_byte;
  logic                        sensor_kind;

  modport source (output valid, output scratch_byte, output sensor_kind, input ready);
  modport sink (input valid, input scratch_byte, input sensor_kind, output ready);
endinterface

interface scc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [scc_pkg::TEMP_W-1:0]  temp_value;
  logic [scc_pkg::STATUS_W-1:0]       status;
  logic [scc_pkg::FAULT_W-1:0]        fault_bits;

  modport source (output valid, output temp_value, output status, output fault_bits,
                  input ready);
  modport sink (input valid, input temp_value, input status, input fault_bits,
                output ready);
endinterface
`default_nettype wire

>>> rtl/scc_in_stage.sv
// input register stage holding one scratchpad word
`timescale 1ns / 1ps
`default_nettype none
module scc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire scc_pkg::in_word_t in_word,
  output logic                   word_valid,
  output scc_pkg::in_word_t      word,
  input  wire logic              word_take
);

  logic              valid_r;
  logic              valid_nxt;
  scc_pkg::in_word_t word_r;

  assign in_ready   = !valid_r || word_take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (word_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule
`default_nettype wire

>>> rtl/scc_frame.sv
// frame tracker: byte position, running crc, captured fields and result build
`timescale 1ns / 1ps
`default_nettype none
module scc_frame (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire scc_pkg::in_word_t word,
  output logic                   at_crc_byte,
  output scc_pkg::out_word_t     result
);

  logic [scc_pkg::POS_W-1:0]   pos_r,   pos_nxt;
  logic [scc_pkg::BYTE_W-1:0]  crc_r,   crc_nxt;
  logic [scc_pkg::BYTE_W-1:0]  low_r,   low_nxt;
  logic [scc_pkg::BYTE_W-1:0]  high_r,  high_nxt;
  logic [scc_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic                        kind_r,  kind_nxt;
  logic [scc_pkg::BYTE_W-1:0]  crc_base;

  assign at_crc_byte = (pos_r >= scc_pkg::POS_CRC);
  assign crc_base    = (pos_r == scc_pkg::POS_TEMP_LOW) ? scc_pkg::CRC_INIT : crc_r;

  // result for the crc byte; crc mismatch wins over a fault
  always_comb begin
    result.temp_value = '0;
    result.status     = scc_pkg::STATUS_OK;
    result.fault_bits = '0;
    if (word.scratch_byte != crc_r) begin
      result.status = scc_pkg::STATUS_CRC_ERR;
    end else if (kind_r && (fault_r != '0)) begin
      result.status     = scc_pkg::STATUS_TC_FAULT;
      result.fault_bits = fault_r;
    end else begin
      result.temp_value = {high_r, low_r};
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    fault_nxt = fault_r;
    kind_nxt  = kind_r;
    if (take) begin
      if (at_crc_byte) begin
        pos_nxt = scc_pkg::POS_TEMP_LOW;
        crc_nxt = scc_pkg::CRC_INIT;
      end else begin
        case (pos_r)
          scc_pkg::POS_TEMP_LOW: begin
            kind_nxt  = word.sensor_kind;
            fault_nxt = '0;
            low_nxt   = word.scratch_byte;
          end
          scc_pkg::POS_TEMP_HIGH: begin
            high_nxt = word.scratch_byte;
          end
          scc_pkg::POS_CONFIG: begin
            fault_nxt = kind_r ? word.scratch_byte[scc_pkg::FAULT_W-1:0] : '0;
          end
          default: begin
          end
        endcase
        crc_nxt = scc_pkg::crc8_update(crc_base, word.scratch_byte);
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= scc_pkg::POS_TEMP_LOW;
      crc_r   <= scc_pkg::CRC_INIT;
      kind_r  <= 1'b0;
      fault_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      kind_r  <= kind_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/sensor_scratchpad_checker_core.sv
// Scratchpad checker top level. Takes the nine scratchpad bytes of a one-wire bus
// temperature read, one word per cycle, runs the reflected CRC-8 (polynomial 0x8C,
// start 0) over bytes 0 to 7, and after byte 8 gives one result word: raw temperature
// in 1/16 degree, status (ok, crc error, thermocouple fault) and fault flags. Bytes
// 0 to 7 give no result. One input word per clock sustained; the result for byte 8
// is registered, passing the input register, then frame logic into the output
// register. The byte-wide CRC update is fully unrolled within the frame stage.
// Output backpressure stalls the input only when a byte 8 is waiting behind an
// untaken result.
`timescale 1ns / 1ps
`default_nettype none
module sensor_scratchpad_checker_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch
);

  scc_pkg::in_word_t  in_word;
  scc_pkg::in_word_t  s1_word;
  scc_pkg::out_word_t result;
  scc_pkg::out_word_t out_r;
  logic               s1_valid;
  logic               s1_take;
  logic               at_crc_byte;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  logic               load_out;

  assign in_word.scratch_byte = in_ch.scratch_byte;
  assign in_word.sensor_kind  = in_ch.sensor_kind;

  scc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_word    (in_word),
    .word_valid (s1_valid),
    .word       (s1_word),
    .word_take  (s1_take)
  );

  scc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (s1_take),
    .word        (s1_word),
    .at_crc_byte (at_crc_byte),
    .result      (result)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_take  = s1_valid && (!at_crc_byte || out_free);
  assign load_out = s1_take && at_crc_byte;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.temp_value = out_r.temp_value;
  assign out_ch.status     = out_r.status;
  assign out_ch.fault_bits = out_r.fault_bits;

endmodule
`default_nettype wire

>>> sim/sensor_scratchpad_checker_core_test.sv
`timescale 1ns / 1ps
// testbench for the scratchpad checker: crc, fault and temperature results
module sensor_scratchpad_checker_core_test;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 12;
  localparam int FRAME_LEN = 9;
  localparam int FRAMES_PER_PHASE = 51;
  localparam int NUM_PHASES = 4;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int DIR_ROWS = 27;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [scc_pkg::BYTE_W-1:0] data;
    logic                       kind;
    logic                       crc_fix;
    logic                       typed;
    scc_pkg::out_word_t         res;
  } scratch_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  scc_in_if in_ch();
  scc_out_if out_ch();

  sensor_scratchpad_checker_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // frame tracker state
  logic [scc_pkg::POS_W-1:0]   frame_pos;
  logic [scc_pkg::BYTE_W-1:0]  crc_acc;
  logic [scc_pkg::BYTE_W-1:0]  lo_byte;
  logic [scc_pkg::BYTE_W-1:0]  hi_byte;
  logic [scc_pkg::FAULT_W-1:0] flt_cap;
  logic                        kind_hold;

  scc_pkg::out_word_t pending_results[$];
  scc_pkg::out_word_t head_result;
  scratch_row_t       dir_tab[DIR_ROWS];

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     holdoff_req = 1'b0;
  bit     holdoff_taken = 1'b0;
  int     holdoff_left = 0;
  int     errors = 0;
  int     bytes_sent = 0;
  int     frames_sent = 0;
  int     result_count = 0;
  int     crc_err_count = 0;
  int     fault_count = 0;
  longint cycle_count = 0;

  function automatic scratch_row_t scratch_row(
      input logic [scc_pkg::BYTE_W-1:0] data,
      input logic kind,
      input logic crc_fix = 1'b0,
      input logic typed = 1'b0,
      input logic signed [scc_pkg::TEMP_W-1:0] temp = '0,
      input logic [scc_pkg::STATUS_W-1:0] status = scc_pkg::STATUS_OK,
      input logic [scc_pkg::FAULT_W-1:0] faults = '0);
    scratch_row_t r;
    r.data = data;
    r.kind = kind;
    r.crc_fix = crc_fix;
    r.typed = typed;
    r.res.temp_value = temp;
    r.res.status = status;
    r.res.fault_bits = faults;
    return r;
  endfunction

  // bitwise lsb-first form of the crc-8
  function automatic logic [scc_pkg::BYTE_W-1:0] crc_step(
      input logic [scc_pkg::BYTE_W-1:0] crc,
      input logic [scc_pkg::BYTE_W-1:0] data);
    logic [scc_pkg::BYTE_W-1:0] c;
    logic                       fb;
    c = crc;
    for (int i = 0; i < scc_pkg::BYTE_W; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ scc_pkg::CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  function automatic void predict_scratch_byte(input logic [scc_pkg::BYTE_W-1:0] b,
                                               input logic k,
                                               output bit done,
                                               output scc_pkg::out_word_t res);
    res = '0;
    done = 1'b0;
    if (frame_pos == scc_pkg::POS_CRC) begin
      done = 1'b1;
      if (b != crc_acc) begin
        res.status = scc_pkg::STATUS_CRC_ERR;
      end else if (kind_hold && flt_cap != '0) begin
        res.status = scc_pkg::STATUS_TC_FAULT;
        res.fault_bits = flt_cap;
      end else begin
        res.status = scc_pkg::STATUS_OK;
        res.temp_value = {hi_byte, lo_byte};
      end
      frame_pos = scc_pkg::POS_TEMP_LOW;
      crc_acc = scc_pkg::CRC_INIT;
    end else begin
      case (frame_pos)
        scc_pkg::POS_TEMP_LOW: begin
          kind_hold = k;
          crc_acc = scc_pkg::CRC_INIT;
          flt_cap = '0;
          lo_byte = b;
        end
        scc_pkg::POS_TEMP_HIGH: begin
          hi_byte = b;
        end
        scc_pkg::POS_CONFIG: begin
          flt_cap = kind_hold ? b[scc_pkg::FAULT_W-1:0] : '0;
        end
        default: begin
        end
      endcase
      crc_acc = crc_step(crc_acc, b);
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_byte(input logic [scc_pkg::BYTE_W-1:0] b, input logic k,
                           input logic crc_fix, input logic typed,
                           input scc_pkg::out_word_t typed_res);
    bit                         done;
    scc_pkg::out_word_t         res;
    logic [scc_pkg::BYTE_W-1:0] data;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    data = crc_fix ? (crc_acc ^ b) : b;
    in_ch.valid <= 1'b1;
    in_ch.scratch_byte <= data;
    in_ch.sensor_kind <= k;
    do @(posedge clk); while (!in_ch.ready);
    predict_scratch_byte(data, k, done, res);
    if (done) begin
      pending_results.push_back(typed ? typed_res : res);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    logic                       k;
    logic [scc_pkg::BYTE_W-1:0] b;
    k = 1'($urandom_range(1));
    for (int p = 0; p < FRAME_LEN; p++) begin
      if (p < 2) begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'h7F;
          2: b = 8'h80;
          3: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end else if (p == 2 && k) begin
        b = 8'($urandom) & 8'hF8;
        if ($urandom_range(1)) begin
          b[scc_pkg::FAULT_W-1:0] = 3'($urandom_range(7, 1));
        end
      end else if (p == FRAME_LEN - 1) begin
        // mostly a matching crc, sometimes a corrupted one
        b = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, (p == 0) ? k : 1'($urandom_range(1)), p == FRAME_LEN - 1, 1'b0, '0);
    end
    frames_sent++;
  endtask

  always @(negedge clk) begin
    if (holdoff_req && !holdoff_taken) begin
      holdoff_taken = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (out_ch.status == scc_pkg::STATUS_CRC_ERR) crc_err_count++;
      if (out_ch.status == scc_pkg::STATUS_TC_FAULT) fault_count++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: temp_value %0d status %0d fault_bits %0d",
                 $time, out_ch.temp_value, out_ch.status, out_ch.fault_bits);
      end else begin
        head_result = pending_results.pop_front();
        if (out_ch.temp_value !== head_result.temp_value) begin
          errors++;
          $display("%0t: temp_value expected %0d, got %0d", $time, head_result.temp_value,
                   out_ch.temp_value);
        end
        if (out_ch.status !== head_result.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, head_result.status,
                   out_ch.status);
        end
        if (out_ch.fault_bits !== head_result.fault_bits) begin
          errors++;
          $display("%0t: fault_bits expected %0d, got %0d", $time, head_result.fault_bits,
                   out_ch.fault_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               pending_results.size());
      $display("sensor_scratchpad_checker_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.scratch_byte = '0;
    in_ch.sensor_kind = 1'b0;
    frame_pos = scc_pkg::POS_TEMP_LOW;
    crc_acc = scc_pkg::CRC_INIT;
    lo_byte = '0;
    hi_byte = '0;
    flt_cap = '0;
    kind_hold = 1'b0;

    dir_tab = '{
      // all zero bytes with a bad crc
      scratch_row(8'h00, 1'b0), scratch_row(8'h00, 1'b0), scratch_row(8'h00, 1'b0),
      scratch_row(8'h00, 1'b0), scratch_row(8'h00, 1'b0), scratch_row(8'h00, 1'b0),
      scratch_row(8'h00, 1'b0), scratch_row(8'h00, 1'b0),
      scratch_row(8'hFF, 1'b0, 1'b0, 1'b1, 16'sh0000, scc_pkg::STATUS_CRC_ERR, 3'd0),
      // thermocouple with open and short-to-supply flags, kind changes later ignored
      scratch_row(8'h00, 1'b1), scratch_row(8'h80, 1'b0), scratch_row(8'hFD, 1'b0),
      scratch_row(8'hFF, 1'b0), scratch_row(8'hFF, 1'b1), scratch_row(8'hFF, 1'b0),
      scratch_row(8'hFF, 1'b1), scratch_row(8'hFF, 1'b0),
      scratch_row(8'h00, 1'b0, 1'b1, 1'b1, 16'sh0000, scc_pkg::STATUS_TC_FAULT, 3'd5),
      // plain sensor at the top of the range, flag bits in byte 2 not checked
      scratch_row(8'hFF, 1'b0), scratch_row(8'h7F, 1'b1), scratch_row(8'h07, 1'b1),
      scratch_row(8'h00, 1'b1), scratch_row(8'hAA, 1'b1), scratch_row(8'h55, 1'b1),
      scratch_row(8'hFF, 1'b1), scratch_row(8'h01, 1'b1),
      scratch_row(8'h00, 1'b1, 1'b1, 1'b1, 16'sh7FFF, scc_pkg::STATUS_OK, 3'd0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].kind, dir_tab[i].crc_fix, dir_tab[i].typed,
                dir_tab[i].res);
    end
    frames_sent += DIR_ROWS / FRAME_LEN;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        // long output hold-off so the block backs up into the input
        if (ph == 0 && f == 10) holdoff_req = 1'b1;
        send_random_frame();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d frames across four flow-control phases and one hold-off",
             bytes_sent, frames_sent);
    $display("checked %0d results: %0d crc errors, %0d thermocouple faults, %0d mismatches",
             result_count, crc_err_count, fault_count, errors);
    if (errors == 0) begin
      $display("sensor_scratchpad_checker_core_test: done, clean");
    end else begin
      $display("sensor_scratchpad_checker_core_test: done, errors");
    end
    $finish;
  end

endmodule
